### src/mrcrc_pkg.sv
// ----------------------------------------------------------------------------
// mrcrc_pkg
// Shared types, constants and the CRC-16/MODBUS byte update.
// ----------------------------------------------------------------------------
package mrcrc_pkg;

    localparam logic [15:0] CrcInit   = 16'hFFFF;
    localparam logic [15:0] CrcPoly   = 16'hA001;
    localparam logic [2:0]  CountSat  = 3'd4;
    localparam logic [2:0]  CountFeed = 3'd2;

    localparam int QueueDepth = 4;
    localparam int QueuePtrW  = 2;

    // job kinds
    localparam logic JOB_SINGLE  = 1'b0;
    localparam logic JOB_TRAILER = 1'b1;

    // result beats of a trailer job
    localparam logic [1:0] BEAT_ECHO   = 2'd0;
    localparam logic [1:0] BEAT_CRC_LO = 2'd1;
    localparam logic [1:0] BEAT_CRC_HI = 2'd2;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data;
        logic        ok;
        logic [15:0] crc;
    } t_job;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
        end
        return c;
    endfunction

endpackage

### src/mrcrc_in_if.sv
// ----------------------------------------------------------------------------
// mrcrc_in_if
// Input channel: one frame byte with its end-of-frame mark.
// ----------------------------------------------------------------------------
interface mrcrc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       frame_end;

    modport source (output valid, output in_byte, output frame_end, input ready);
    modport sink   (input valid, input in_byte, input frame_end, output ready);
endinterface

### src/mrcrc_out_if.sv
// ----------------------------------------------------------------------------
// mrcrc_out_if
// Output channel: one result byte with its status fields.
// ----------------------------------------------------------------------------
interface mrcrc_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        run_last;
    logic        crc_ok;
    logic [15:0] crc_value;

    modport source (output valid, output out_byte, output run_last, output crc_ok,
                    output crc_value, input ready);
    modport sink   (input valid, input out_byte, input run_last, input crc_ok,
                    input crc_value, output ready);
endinterface

### src/mrcrc_front.sv
// ----------------------------------------------------------------------------
// mrcrc_front
// Accepts frame bytes, keeps the CRC and holdback state, and posts jobs.
// ----------------------------------------------------------------------------
module mrcrc_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    mrcrc_in_if.sink           i_in,
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata,
    input  logic               i_q_full,
    output logic               o_push,
    output mrcrc_pkg::t_job    o_job
);

    logic        r_mode;
    logic [15:0] r_crc;
    logic [7:0]  r_hb0;
    logic [7:0]  r_hb1;
    logic [2:0]  r_cnt;

    logic [15:0] n_crc;
    logic [7:0]  n_hb0;
    logic [7:0]  n_hb1;
    logic [2:0]  n_cnt;

    logic        accept;
    logic [7:0]  feed_in;
    logic [15:0] fed;
    logic [15:0] chk_crc;
    logic [2:0]  cnt_inc;
    logic        ok;

    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && i_in.ready;

    // check mode feeds the older held byte, append mode the new byte
    assign feed_in = r_mode ? r_hb0 : i_in.in_byte;
    assign fed     = mrcrc_pkg::crc_feed(r_crc, feed_in);
    assign chk_crc = (r_cnt >= mrcrc_pkg::CountFeed) ? fed : r_crc;
    assign cnt_inc = (r_cnt < mrcrc_pkg::CountSat) ? r_cnt + 3'd1 : r_cnt;
    assign ok      = (cnt_inc == mrcrc_pkg::CountSat)
                  && (r_hb1 == chk_crc[7:0])
                  && (i_in.in_byte == chk_crc[15:8]);

    always_comb begin
        o_push = accept && (!r_mode || i_in.frame_end);
        if (r_mode) begin
            o_job.kind = mrcrc_pkg::JOB_SINGLE;
            o_job.data = 8'h00;
            o_job.ok   = ok;
            o_job.crc  = chk_crc;
        end else begin
            o_job.kind = i_in.frame_end ? mrcrc_pkg::JOB_TRAILER : mrcrc_pkg::JOB_SINGLE;
            o_job.data = i_in.in_byte;
            o_job.ok   = 1'b0;
            o_job.crc  = fed;
        end
    end

    always_comb begin
        n_crc = r_crc;
        n_hb0 = r_hb0;
        n_hb1 = r_hb1;
        n_cnt = r_cnt;
        if (i_cfg_we || (accept && i_in.frame_end)) begin
            // restart the frame
            n_crc = mrcrc_pkg::CrcInit;
            n_hb0 = 8'h00;
            n_hb1 = 8'h00;
            n_cnt = 3'd0;
        end else if (accept) begin
            if (r_mode) begin
                n_crc = chk_crc;
                n_hb0 = r_hb1;
                n_hb1 = i_in.in_byte;
                n_cnt = cnt_inc;
            end else begin
                n_crc = fed;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_crc  <= mrcrc_pkg::CrcInit;
            r_hb0  <= 8'h00;
            r_hb1  <= 8'h00;
            r_cnt  <= 3'd0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            r_crc <= n_crc;
            r_hb0 <= n_hb0;
            r_hb1 <= n_hb1;
            r_cnt <= n_cnt;
        end
    end

endmodule

### src/mrcrc_queue.sv
// ----------------------------------------------------------------------------
// mrcrc_queue
// Small job queue between the front and back parts.
// ----------------------------------------------------------------------------
module mrcrc_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  mrcrc_pkg::t_job    i_job,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_valid,
    output mrcrc_pkg::t_job    o_job
);

    mrcrc_pkg::t_job r_mem [mrcrc_pkg::QueueDepth];

    logic [mrcrc_pkg::QueuePtrW-1:0] r_wr;
    logic [mrcrc_pkg::QueuePtrW-1:0] r_rd;
    logic [mrcrc_pkg::QueuePtrW:0]   r_cnt;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_cnt == (mrcrc_pkg::QueuePtrW+1)'(mrcrc_pkg::QueueDepth));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

### src/mrcrc_back.sv
// ----------------------------------------------------------------------------
// mrcrc_back
// Expands queued jobs into result items on the output channel.
// ----------------------------------------------------------------------------
module mrcrc_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  mrcrc_pkg::t_job    i_q_job,
    output logic               o_pop,
    mrcrc_out_if.source        o_out
);

    logic            r_valid;
    logic [1:0]      r_beat;
    mrcrc_pkg::t_job r_job;

    logic last;
    logic free;

    assign last  = (r_job.kind == mrcrc_pkg::JOB_SINGLE) || (r_beat == mrcrc_pkg::BEAT_CRC_HI);
    assign free  = !r_valid || (o_out.ready && last);
    assign o_pop = i_q_valid && free;

    assign o_out.valid     = r_valid;
    assign o_out.run_last  = last;
    assign o_out.crc_ok    = r_job.ok;
    assign o_out.crc_value = r_job.crc;

    always_comb begin
        unique case (r_beat)
            mrcrc_pkg::BEAT_ECHO:   o_out.out_byte = r_job.data;
            mrcrc_pkg::BEAT_CRC_LO: o_out.out_byte = r_job.crc[7:0];
            mrcrc_pkg::BEAT_CRC_HI: o_out.out_byte = r_job.crc[15:8];
            default:                o_out.out_byte = r_job.data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_q_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_beat  <= mrcrc_pkg::BEAT_ECHO;
        end else if (free) begin
            r_valid <= i_q_valid;
            r_beat  <= mrcrc_pkg::BEAT_ECHO;
        end else if (o_out.ready) begin
            // advance to the next trailer beat
            r_beat <= r_beat + 2'd1;
        end
    end

endmodule

### src/modbus_rtu_crc_append_check.sv
// ----------------------------------------------------------------------------
// modbus_rtu_crc_append_check
// CRC-16/MODBUS appender and checker for Modbus RTU frames.
// ----------------------------------------------------------------------------
// Frame bytes enter on i_in (valid/ready), frame_end marking the final byte.
// Results leave on o_out (valid/ready). i_cfg_we/i_cfg_wdata set check mode
// (0 append, 1 check); a write also restarts the current frame.
// Append mode: every byte is echoed; the final byte is followed by the CRC
// low byte and then the high byte, which carries run_last.
// Check mode: no result until the final byte, then one verdict item with
// crc_ok set when the trailer matches and the frame has at least four bytes.
// The front part updates the CRC in the cycle a byte is accepted and posts a
// job to a four-entry queue; the back part turns each job into items.
// Each result is registered in the queue and then in the back output stage.
// Throughput: one byte per cycle while the queue has room; a final byte in
// append mode gives three items; the output port sets the rate of such frames.
// Reset clears the CRC, holdback, count, queue and output, and selects append
// mode. When the receiver stalls, the output holds its item, the queue fills,
// and i_in.ready drops once four jobs are waiting.
// ----------------------------------------------------------------------------
module modbus_rtu_crc_append_check (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mrcrc_in_if.sink    i_in,
    mrcrc_out_if.source o_out,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata
);

    logic            q_push;
    logic            q_full;
    logic            q_pop;
    logic            q_valid;
    mrcrc_pkg::t_job push_job;
    mrcrc_pkg::t_job head_job;

    mrcrc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_job       (push_job)
    );

    mrcrc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (head_job)
    );

    mrcrc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_job   (head_job),
        .o_pop     (q_pop),
        .o_out     (o_out)
    );

`ifndef SYNTHESIS
    a_verdict_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.crc_ok |-> o_out.run_last && (o_out.out_byte == 8'h00))
        else $error("crc_ok on a non-verdict item");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid right after reset");

    a_no_idle_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_valid && !q_pop |-> o_out.valid)
        else $error("job waiting while output stage is empty");

    a_no_lost_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("job pushed into a full queue");
`endif

endmodule
